// ===== rtl/arc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARC package
// Shared types and constants for the adaptive replacement cache directory.
// ----------------------------------------------------------------------------
package arc_pkg;

   localparam int PAGE_W = 32;
   localparam int SIZE_W = 7;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

   typedef enum logic [1:0] {
      LIST_T1 = 2'd0,
      LIST_T2 = 2'd1,
      LIST_B1 = 2'd2,
      LIST_B2 = 2'd3
   } arc_list_type;

   typedef enum logic [1:0] {
      GHOST_NONE = 2'd0,
      GHOST_B1   = 2'd1,
      GHOST_B2   = 2'd2
   } arc_ghost_type;

   // How a full miss makes room.
   typedef enum logic [2:0] {
      MC_NONE,
      MC_B1_FULL,
      MC_T1_FULL,
      MC_DROP_B2,
      MC_REPL
   } arc_mcase_type;

   typedef enum logic [1:0] {
      US_HIT,
      US_REP,
      US_DROP,
      US_T1
   } arc_unl_sel_type;

   typedef enum logic [1:0] {
      PS_T1,
      PS_T2,
      PS_REP
   } arc_push_sel_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_DIV,
      ST_ADAPT,
      ST_REPL,
      ST_REP_UNL,
      ST_REP_WAIT,
      ST_REP_PUSH,
      ST_HIT_UNL,
      ST_HIT_WAIT,
      ST_PUSH_T2,
      ST_DROP_UNL,
      ST_DROP_WAIT,
      ST_T1_UNL,
      ST_T1_WAIT,
      ST_PUSH_T1,
      ST_DONE
   } arc_state_type;

   typedef struct packed {
      logic             scan_go;
      logic             decide;
      logic             div_go;
      logic             adapt;
      logic             repl;
      logic             unl_go;
      arc_unl_sel_type  unl_sel;
      logic             push_go;
      arc_push_sel_type push_sel;
      logic             finish;
   } arc_cmd_type;

   typedef struct packed {
      logic          sweep_busy;
      logic          div_busy;
      logic          is_hit;
      logic          is_ghost;
      arc_mcase_type mcase;
   } arc_stat_type;

endpackage

// ===== rtl/adaptive_replacement_cache.sv =====
`timescale 1ns / 1ps
// Each request runs one directory scan and, on a ghost hit, a divide, then up to two
// unlink sweeps, with sequencing states between these steps.
// One request at a time; the next is taken in the cycle that shows the result strobe.
// The directory memory has one read port, so each sweep visits one entry per cycle.
// Synchronous reset empties all lists at once and sets the cache size to 64.
// ----------------------------------------------------------------------------
// Adaptive replacement cache
// Top level of the ARC directory: controller, datapath and configuration port.
// ----------------------------------------------------------------------------
module adaptive_replacement_cache #(
   parameter int CAPACITY = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [arc_pkg::PAGE_W-1:0]  req_page,
   output logic                        rsp_valid,
   output logic                        rsp_hit,
   output logic [1:0]                  rsp_ghost_hit,
   output logic                        rsp_evict_valid,
   output logic [arc_pkg::PAGE_W-1:0]  rsp_evicted_page,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [arc_pkg::SIZE_W-1:0]  csr_cache_size
);

   arc_pkg::arc_cmd_type  cmd;
   arc_pkg::arc_stat_type stat;

   assign csr_ready = !busy;

   arc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   arc_dpath #(.CAPACITY(CAPACITY)) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_page         (req_page),
      .cfg_we           (csr_valid && csr_ready),
      .cfg_size         (csr_cache_size),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_ghost_hit    (rsp_ghost_hit),
      .rsp_evict_valid  (rsp_evict_valid),
      .rsp_evicted_page (rsp_evicted_page)
   );

endmodule

// ===== rtl/arc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARC divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module arc_div #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         busy,
   output logic [W-1:0] quotient
);

   localparam int CW = $clog2(W + 1);

   logic [W:0]    rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  dvs_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W:0]    shifted;

   assign shifted = {rem_ff[W-1:0], quo_ff[W-1]};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = CW'(W);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = shifted - {1'b0, dvs_ff};
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff;

endmodule

// ===== rtl/arc_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARC datapath
// Directory memory with sweep engine, list counts, target and result registers.
// ----------------------------------------------------------------------------
module arc_dpath #(
   parameter int CAPACITY = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [arc_pkg::PAGE_W-1:0]  req_page,
   input  logic                        cfg_we,
   input  logic [arc_pkg::SIZE_W-1:0]  cfg_size,
   input  arc_pkg::arc_cmd_type        cmd,
   output arc_pkg::arc_stat_type       stat,
   output logic                        rsp_valid,
   output logic                        rsp_hit,
   output logic [1:0]                  rsp_ghost_hit,
   output logic                        rsp_evict_valid,
   output logic [arc_pkg::PAGE_W-1:0]  rsp_evicted_page
);

   localparam int DEPTH = 2 * CAPACITY;
   localparam int IW    = $clog2(DEPTH);
   localparam int CNTW  = $clog2(DEPTH + 1);
   localparam int TW    = $clog2(CAPACITY + 1);
   localparam int AW    = (CNTW + 1 > 8) ? CNTW + 1 : 8;
   localparam logic [AW-1:0] CAP_A = AW'(CAPACITY);

   typedef struct packed {
      logic [arc_pkg::PAGE_W-1:0] page;
      arc_pkg::arc_list_type      list;
      logic [IW-1:0]              rank;
   } entry_type;

   // Directory storage
   entry_type            mem [DEPTH];
   entry_type            rd_data_ff;
   logic [DEPTH-1:0]     valid_ff;
   logic                 wr_en;
   logic [IW-1:0]        wr_idx;
   entry_type            wr_data;

   logic [arc_pkg::SIZE_W-1:0] cache_size_ff;
   logic [CNTW-1:0]            count_ff [4];
   logic [TW-1:0]              target_ff;
   logic [arc_pkg::PAGE_W-1:0] page_ff;

   // Sweep engine
   logic          sweep_act_ff, sweep_find_ff, pend_ff;
   logic [IW:0]   addr_ff;
   logic [IW-1:0] pidx_ff;
   logic          start_sweep;

   // Scan results
   logic                       hit_found_ff;
   logic [IW-1:0]              hit_idx_ff;
   arc_pkg::arc_list_type      hit_list_ff;
   logic [IW-1:0]              hit_rank_ff;
   logic [3:0]                 lru_found_ff;
   logic [IW-1:0]              lru_idx_ff  [4];
   logic [arc_pkg::PAGE_W-1:0] lru_page_ff [4];

   // Free slot stack
   logic [IW-1:0] fs_ff [3];
   logic [1:0]    fs_cnt_ff;

   // Unlink and replacement state
   arc_pkg::arc_list_type      unl_list_ff, rep_src_ff;
   logic [IW-1:0]              unl_rank_ff;
   logic                       rep_ok_ff;
   logic [arc_pkg::PAGE_W-1:0] rep_page_ff;
   arc_pkg::arc_mcase_type     mcase_ff, mcase;

   // Results
   logic                       rsp_valid_ff, res_hit_ff, ev_valid_ff;
   arc_pkg::arc_ghost_type     res_ghost_ff;
   logic [arc_pkg::PAGE_W-1:0] ev_page_ff;

   // Arithmetic views of the counts
   logic [AW-1:0] t1_a, t2_a, b1_a, b2_a, total_a, size_a, c_a, tgt_a, d_a, sum_a;
   logic          ghost_b2, use_one;
   logic [CNTW-1:0] quotient;
   logic            div_busy;

   assign t1_a    = AW'(count_ff[arc_pkg::LIST_T1]);
   assign t2_a    = AW'(count_ff[arc_pkg::LIST_T2]);
   assign b1_a    = AW'(count_ff[arc_pkg::LIST_B1]);
   assign b2_a    = AW'(count_ff[arc_pkg::LIST_B2]);
   assign total_a = t1_a + t2_a + b1_a + b2_a;
   assign size_a  = AW'(cache_size_ff);
   assign c_a     = (size_a == '0) ? AW'(1) : ((size_a > CAP_A) ? CAP_A : size_a);
   assign tgt_a   = AW'(target_ff);

   assign ghost_b2 = (hit_list_ff == arc_pkg::LIST_B2);

   always_comb begin
      if (t1_a + b1_a >= c_a) begin
         mcase = (t1_a < c_a) ? arc_pkg::MC_B1_FULL : arc_pkg::MC_T1_FULL;
      end else if (total_a >= c_a) begin
         mcase = (total_a >= (c_a << 1)) ? arc_pkg::MC_DROP_B2 : arc_pkg::MC_REPL;
      end else begin
         mcase = arc_pkg::MC_NONE;
      end
   end

   arc_div #(.W(CNTW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_go),
      .dividend (ghost_b2 ? count_ff[arc_pkg::LIST_B1] : count_ff[arc_pkg::LIST_B2]),
      .divisor  (ghost_b2 ? count_ff[arc_pkg::LIST_B2] : count_ff[arc_pkg::LIST_B1]),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // The adaptation step is 1 unless the other ghost list is the longer one.
   assign use_one = ghost_b2 ? ((b2_a >= b1_a) || (b2_a == '0))
                             : ((b1_a >= b2_a) || (b1_a == '0));
   assign d_a     = use_one ? AW'(1) : AW'(quotient);
   assign sum_a   = tgt_a + d_a;

   // Replacement source selection
   arc_pkg::arc_list_type repl_src;
   logic                  sel_t1;
   always_comb begin
      sel_t1 = (t1_a != '0) && ((t1_a > tgt_a) || (ghost_b2 && hit_found_ff && t1_a == tgt_a));
      repl_src = sel_t1 ? arc_pkg::LIST_T1 : arc_pkg::LIST_T2;
      if (count_ff[repl_src] == '0) begin
         repl_src = sel_t1 ? arc_pkg::LIST_T2 : arc_pkg::LIST_T1;
      end
   end

   // Unlink target selection
   arc_pkg::arc_list_type lsel, unl_l;
   logic                  unl_ok, unl_fire;
   logic [IW-1:0]         unl_idx, unl_rank;

   always_comb begin
      case (cmd.unl_sel)
         arc_pkg::US_DROP: lsel = (mcase_ff == arc_pkg::MC_B1_FULL) ? arc_pkg::LIST_B1
                                                                   : arc_pkg::LIST_B2;
         arc_pkg::US_T1:   lsel = arc_pkg::LIST_T1;
         default:          lsel = rep_src_ff;
      endcase
      if (cmd.repl) begin
         lsel = repl_src;
      end
   end

   always_comb begin
      if (cmd.unl_sel == arc_pkg::US_HIT) begin
         unl_l    = hit_list_ff;
         unl_idx  = hit_idx_ff;
         unl_rank = hit_rank_ff;
         unl_ok   = hit_found_ff;
      end else begin
         unl_l    = lsel;
         unl_idx  = lru_idx_ff[lsel];
         unl_rank = '0;
         unl_ok   = lru_found_ff[lsel] &&
                    ((cmd.unl_sel != arc_pkg::US_REP) || rep_ok_ff);
      end
   end

   assign unl_fire    = cmd.unl_go && unl_ok;
   assign start_sweep = cmd.scan_go || unl_fire;

   // Push selection
   arc_pkg::arc_list_type      push_l;
   logic [arc_pkg::PAGE_W-1:0] push_page;
   logic                       push_fire;
   logic [IW-1:0]              push_idx;

   always_comb begin
      case (cmd.push_sel)
         arc_pkg::PS_T1: begin
            push_l    = arc_pkg::LIST_T1;
            push_page = page_ff;
         end
         arc_pkg::PS_T2: begin
            push_l    = arc_pkg::LIST_T2;
            push_page = page_ff;
         end
         default: begin
            push_l    = (rep_src_ff == arc_pkg::LIST_T1) ? arc_pkg::LIST_B1 : arc_pkg::LIST_B2;
            push_page = rep_page_ff;
         end
      endcase
   end

   assign push_fire = cmd.push_go && (fs_cnt_ff != '0) &&
                      ((cmd.push_sel != arc_pkg::PS_REP) || rep_ok_ff);
   assign push_idx  = fs_ff[fs_cnt_ff - 2'd1];

   // Sweep processing of the registered read data
   logic pv, dec_hit;
   assign pv      = pend_ff && valid_ff[pidx_ff];
   assign dec_hit = pend_ff && !sweep_find_ff && pv && (rd_data_ff.list == unl_list_ff) &&
                    (rd_data_ff.rank > unl_rank_ff);

   always_comb begin
      wr_en   = 1'b0;
      wr_idx  = push_idx;
      wr_data = '{page: push_page, list: push_l, rank: IW'(count_ff[push_l])};
      if (push_fire) begin
         wr_en = 1'b1;
      end else if (dec_hit) begin
         wr_en   = 1'b1;
         wr_idx  = pidx_ff;
         wr_data = rd_data_ff;
         wr_data.rank = rd_data_ff.rank - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= mem[addr_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_act_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         pend_ff <= sweep_act_ff;
         if (start_sweep) begin
            sweep_act_ff <= 1'b1;
         end else if (sweep_act_ff && addr_ff == (IW + 1)'(DEPTH - 1)) begin
            sweep_act_ff <= 1'b0;
         end
      end
      pidx_ff <= addr_ff[IW-1:0];
      if (start_sweep) begin
         addr_ff       <= '0;
         sweep_find_ff <= cmd.scan_go;
      end else if (sweep_act_ff) begin
         addr_ff <= addr_ff + 1'b1;
      end
   end

   // Directory control state
   always_ff @(posedge clock) begin
      if (reset || cfg_we) begin
         valid_ff  <= '0;
         target_ff <= '0;
         for (int i = 0; i < 4; i++) begin
            count_ff[i] <= '0;
         end
         cache_size_ff <= reset ? arc_pkg::SIZE_RESET : cfg_size;
      end else begin
         if (unl_fire) begin
            valid_ff[unl_idx] <= 1'b0;
            if (count_ff[unl_l] != '0) begin
               count_ff[unl_l] <= count_ff[unl_l] - 1'b1;
            end
         end
         if (push_fire) begin
            valid_ff[push_idx] <= 1'b1;
            count_ff[push_l]   <= count_ff[push_l] + 1'b1;
         end
         if (cmd.adapt) begin
            if (ghost_b2) begin
               target_ff <= (tgt_a > d_a) ? TW'(tgt_a - d_a) : '0;
            end else begin
               target_ff <= (sum_a > c_a) ? TW'(c_a) : TW'(sum_a);
            end
         end
      end
   end

   // Scan results and free slot stack
   always_ff @(posedge clock) begin
      if (reset) begin
         fs_cnt_ff <= '0;
      end else if (cmd.scan_go) begin
         fs_cnt_ff <= '0;
      end else if (pend_ff && sweep_find_ff && !pv && fs_cnt_ff == '0) begin
         fs_ff[0]  <= pidx_ff;
         fs_cnt_ff <= 2'd1;
      end else if (unl_fire && fs_cnt_ff != 2'd3) begin
         fs_ff[fs_cnt_ff] <= unl_idx;
         fs_cnt_ff        <= fs_cnt_ff + 2'd1;
      end else if (push_fire) begin
         fs_cnt_ff <= fs_cnt_ff - 2'd1;
      end

      if (cmd.scan_go) begin
         page_ff      <= req_page;
         hit_found_ff <= 1'b0;
         lru_found_ff <= '0;
      end else if (pend_ff && sweep_find_ff && pv) begin
         if (rd_data_ff.page == page_ff) begin
            hit_found_ff <= 1'b1;
            hit_idx_ff   <= pidx_ff;
            hit_list_ff  <= rd_data_ff.list;
            hit_rank_ff  <= rd_data_ff.rank;
         end
         if (rd_data_ff.rank == '0) begin
            lru_found_ff[rd_data_ff.list] <= 1'b1;
            lru_idx_ff[rd_data_ff.list]   <= pidx_ff;
            lru_page_ff[rd_data_ff.list]  <= rd_data_ff.page;
         end
      end

      if (unl_fire) begin
         unl_list_ff <= unl_l;
         unl_rank_ff <= unl_rank;
      end
      if (cmd.decide) begin
         mcase_ff <= mcase;
      end
      if (cmd.repl) begin
         rep_src_ff  <= repl_src;
         rep_ok_ff   <= lru_found_ff[lsel];
         rep_page_ff <= lru_page_ff[lsel];
      end
   end

   // Result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
      end
      if (cmd.scan_go) begin
         ev_valid_ff <= 1'b0;
         ev_page_ff  <= '0;
      end else if (cmd.repl && lru_found_ff[lsel]) begin
         ev_valid_ff <= 1'b1;
         ev_page_ff  <= lru_page_ff[lsel];
      end else if (unl_fire && cmd.unl_sel == arc_pkg::US_T1) begin
         ev_valid_ff <= 1'b1;
         ev_page_ff  <= lru_page_ff[lsel];
      end
      if (cmd.decide) begin
         res_hit_ff   <= stat.is_hit;
         res_ghost_ff <= !stat.is_ghost ? arc_pkg::GHOST_NONE :
                         (ghost_b2 ? arc_pkg::GHOST_B2 : arc_pkg::GHOST_B1);
      end
   end

   assign stat.sweep_busy = sweep_act_ff || pend_ff;
   assign stat.div_busy   = div_busy;
   assign stat.is_hit     = hit_found_ff && (hit_list_ff == arc_pkg::LIST_T1 ||
                                             hit_list_ff == arc_pkg::LIST_T2);
   assign stat.is_ghost   = hit_found_ff && (hit_list_ff == arc_pkg::LIST_B1 ||
                                             hit_list_ff == arc_pkg::LIST_B2);
   assign stat.mcase      = mcase;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = res_hit_ff;
   assign rsp_ghost_hit    = res_ghost_ff;
   assign rsp_evict_valid  = ev_valid_ff;
   assign rsp_evicted_page = ev_page_ff;

endmodule

// ===== rtl/arc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARC controller
// Sequences the scan, adaptation, unlink and insert steps of one request.
// ----------------------------------------------------------------------------
module arc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  arc_pkg::arc_stat_type stat,
   output arc_pkg::arc_cmd_type  cmd,
   output logic                  busy
);

   arc_pkg::arc_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= arc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         arc_pkg::ST_IDLE: begin
            if (start) begin
               cmd.scan_go = 1'b1;
               state_in    = arc_pkg::ST_SCAN;
            end
         end
         arc_pkg::ST_SCAN: begin
            if (!stat.sweep_busy) state_in = arc_pkg::ST_DECIDE;
         end
         arc_pkg::ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (stat.is_hit) begin
               state_in = arc_pkg::ST_HIT_UNL;
            end else if (stat.is_ghost) begin
               cmd.div_go = 1'b1;
               state_in   = arc_pkg::ST_DIV;
            end else begin
               case (stat.mcase)
                  arc_pkg::MC_B1_FULL: state_in = arc_pkg::ST_DROP_UNL;
                  arc_pkg::MC_DROP_B2: state_in = arc_pkg::ST_DROP_UNL;
                  arc_pkg::MC_T1_FULL: state_in = arc_pkg::ST_T1_UNL;
                  arc_pkg::MC_REPL:    state_in = arc_pkg::ST_REPL;
                  default:             state_in = arc_pkg::ST_PUSH_T1;
               endcase
            end
         end
         arc_pkg::ST_DIV: begin
            if (!stat.div_busy) state_in = arc_pkg::ST_ADAPT;
         end
         arc_pkg::ST_ADAPT: begin
            cmd.adapt = 1'b1;
            state_in  = arc_pkg::ST_REPL;
         end
         arc_pkg::ST_REPL: begin
            cmd.repl = 1'b1;
            state_in = arc_pkg::ST_REP_UNL;
         end
         arc_pkg::ST_REP_UNL: begin
            cmd.unl_go  = 1'b1;
            cmd.unl_sel = arc_pkg::US_REP;
            state_in    = arc_pkg::ST_REP_WAIT;
         end
         arc_pkg::ST_REP_WAIT: begin
            if (!stat.sweep_busy) state_in = arc_pkg::ST_REP_PUSH;
         end
         arc_pkg::ST_REP_PUSH: begin
            cmd.push_go  = 1'b1;
            cmd.push_sel = arc_pkg::PS_REP;
            state_in     = stat.is_ghost ? arc_pkg::ST_HIT_UNL : arc_pkg::ST_PUSH_T1;
         end
         arc_pkg::ST_HIT_UNL: begin
            cmd.unl_go  = 1'b1;
            cmd.unl_sel = arc_pkg::US_HIT;
            state_in    = arc_pkg::ST_HIT_WAIT;
         end
         arc_pkg::ST_HIT_WAIT: begin
            if (!stat.sweep_busy) state_in = arc_pkg::ST_PUSH_T2;
         end
         arc_pkg::ST_PUSH_T2: begin
            cmd.push_go  = 1'b1;
            cmd.push_sel = arc_pkg::PS_T2;
            state_in     = arc_pkg::ST_DONE;
         end
         arc_pkg::ST_DROP_UNL: begin
            cmd.unl_go  = 1'b1;
            cmd.unl_sel = arc_pkg::US_DROP;
            state_in    = arc_pkg::ST_DROP_WAIT;
         end
         arc_pkg::ST_DROP_WAIT: begin
            if (!stat.sweep_busy) state_in = arc_pkg::ST_REPL;
         end
         arc_pkg::ST_T1_UNL: begin
            cmd.unl_go  = 1'b1;
            cmd.unl_sel = arc_pkg::US_T1;
            state_in    = arc_pkg::ST_T1_WAIT;
         end
         arc_pkg::ST_T1_WAIT: begin
            if (!stat.sweep_busy) state_in = arc_pkg::ST_PUSH_T1;
         end
         arc_pkg::ST_PUSH_T1: begin
            cmd.push_go  = 1'b1;
            cmd.push_sel = arc_pkg::PS_T1;
            state_in     = arc_pkg::ST_DONE;
         end
         arc_pkg::ST_DONE: begin
            cmd.finish = 1'b1;
            state_in   = arc_pkg::ST_IDLE;
         end
         default: state_in = arc_pkg::ST_IDLE;
      endcase
   end

   assign busy = (state_ff != arc_pkg::ST_IDLE);

endmodule

// ===== rtl/arc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARC checker
// Port-level assertions on the cache's request and result behaviour.
// ----------------------------------------------------------------------------
module arc_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_hit,
   input logic [1:0]  rsp_ghost_hit,
   input logic        rsp_evict_valid,
   input logic [31:0] rsp_evicted_page
);

   // Each transaction yields a single one-cycle result.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("not busy after accepted request");

   a_evict_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_evict_valid) |-> (rsp_evicted_page == 32'd0))
      else $error("evicted page set without eviction");

   // A resident hit neither hits a ghost nor evicts.
   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (rsp_ghost_hit == 2'd0 && !rsp_evict_valid))
      else $error("resident hit with ghost hit or eviction");

endmodule

bind adaptive_replacement_cache arc_checker u_arc_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_hit          (rsp_hit),
   .rsp_ghost_hit    (rsp_ghost_hit),
   .rsp_evict_valid  (rsp_evict_valid),
   .rsp_evicted_page (rsp_evicted_page)
);

// ===== test/adaptive_replacement_cache_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive replacement cache testbench
// Sends page requests through the start/busy handshake and writes the cache
// size through the CSR channel between phases. A short table of directed
// requests comes first, then random traffic over small page pools. Results are
// checked field by field against fixed values or a queue-based ARC predictor.
// ----------------------------------------------------------------------------
module adaptive_replacement_cache_test;

   localparam int CAP       = 64;
   localparam int LIMIT     = 3000000;
   localparam int N_PHASES  = 8;
   localparam int PHASE_LEN = 165;

   typedef struct packed {
      logic                       hit;
      logic [1:0]                 ghost;
      logic                       evict_valid;
      logic [arc_pkg::PAGE_W-1:0] evicted_page;
   } arc_result_type;

   typedef struct {
      bit                         is_cfg;
      bit                         fixed;
      logic [arc_pkg::PAGE_W-1:0] value;
      arc_result_type             res;
   } stim_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [arc_pkg::PAGE_W-1:0] req_page = '0;
   logic                       rsp_valid;
   logic                       rsp_hit;
   logic [1:0]                 rsp_ghost_hit;
   logic                       rsp_evict_valid;
   logic [arc_pkg::PAGE_W-1:0] rsp_evicted_page;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [arc_pkg::SIZE_W-1:0] csr_cache_size = '0;

   adaptive_replacement_cache #(.CAPACITY(CAP)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_page         (req_page),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_ghost_hit    (rsp_ghost_hit),
      .rsp_evict_valid  (rsp_evict_valid),
      .rsp_evicted_page (rsp_evicted_page),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_cache_size   (csr_cache_size)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state: one queue per list, index 0 is the least recent page.
   logic [arc_pkg::PAGE_W-1:0] arc_lists [4][$];
   logic [arc_pkg::SIZE_W-1:0] size_reg = arc_pkg::SIZE_RESET;
   int                         recent_target = 0;

   arc_result_type    pending_results [$];
   stim_row_type      dir_rows [$];
   int                errors = 0;
   int                cycles = 0;
   bit                allow_idle = 1'b1;

   function automatic void flush_lists();
      for (int l = 0; l < 4; l++) arc_lists[l].delete();
      recent_target = 0;
   endfunction

   function automatic bit locate(input logic [arc_pkg::PAGE_W-1:0] pg, output int l,
                                 output int pos);
      for (l = 0; l < 4; l++)
         for (pos = 0; pos < arc_lists[l].size(); pos++)
            if (arc_lists[l][pos] == pg) return 1'b1;
      return 1'b0;
   endfunction

   function automatic void make_room(input bit in_b2, inout arc_result_type r);
      int t1;
      int src;
      int dst;
      logic [arc_pkg::PAGE_W-1:0] pg;
      t1 = arc_lists[int'(arc_pkg::LIST_T1)].size();
      if (t1 >= 1 && (t1 > recent_target || (in_b2 && t1 == recent_target))) begin
         src = int'(arc_pkg::LIST_T1); dst = int'(arc_pkg::LIST_B1);
      end else begin
         src = int'(arc_pkg::LIST_T2); dst = int'(arc_pkg::LIST_B2);
      end
      if (arc_lists[src].size() == 0) begin
         src = src ^ 1; dst = src + 2;
      end
      if (arc_lists[src].size() == 0) return;
      pg = arc_lists[src].pop_front();
      arc_lists[dst].push_back(pg);
      r.evict_valid  = 1'b1;
      r.evicted_page = pg;
   endfunction

   function automatic arc_result_type arc_lookup(input logic [arc_pkg::PAGE_W-1:0] pg);
      arc_result_type r;
      int c;
      int l;
      int pos;
      int b1;
      int b2;
      int d;
      int t1;
      int total;
      r = '0;
      c = (size_reg == 0) ? 1 : ((size_reg > CAP) ? CAP : int'(size_reg));
      if (locate(pg, l, pos) &&
          (l == int'(arc_pkg::LIST_T1) || l == int'(arc_pkg::LIST_T2))) begin
         r.hit = 1'b1;
         arc_lists[l].delete(pos);
         arc_lists[int'(arc_pkg::LIST_T2)].push_back(pg);
      end else if (locate(pg, l, pos)) begin
         b1 = arc_lists[int'(arc_pkg::LIST_B1)].size();
         b2 = arc_lists[int'(arc_pkg::LIST_B2)].size();
         if (l == int'(arc_pkg::LIST_B1)) begin
            r.ghost = arc_pkg::GHOST_B1;
            d = (b1 >= b2 || b1 == 0) ? 1 : b2 / b1;
            recent_target = (recent_target + d > c) ? c : recent_target + d;
            make_room(1'b0, r);
         end else begin
            r.ghost = arc_pkg::GHOST_B2;
            d = (b2 >= b1 || b2 == 0) ? 1 : b1 / b2;
            if (d == 0) d = 1;
            recent_target = (recent_target > d) ? recent_target - d : 0;
            make_room(1'b1, r);
         end
         if (locate(pg, l, pos)) arc_lists[l].delete(pos);
         arc_lists[int'(arc_pkg::LIST_T2)].push_back(pg);
      end else begin
         t1 = arc_lists[int'(arc_pkg::LIST_T1)].size();
         b1 = arc_lists[int'(arc_pkg::LIST_B1)].size();
         if (t1 + b1 >= c) begin
            if (t1 < c) begin
               if (b1 > 0) void'(arc_lists[int'(arc_pkg::LIST_B1)].pop_front());
               make_room(1'b0, r);
            end else if (t1 > 0) begin
               // T1 alone fills the cache: its oldest page leaves without a ghost.
               r.evict_valid  = 1'b1;
               r.evicted_page = arc_lists[int'(arc_pkg::LIST_T1)].pop_front();
            end
         end else begin
            total = 0;
            for (int k = 0; k < 4; k++) total += arc_lists[k].size();
            if (total >= c) begin
               if (total >= 2 * c && arc_lists[int'(arc_pkg::LIST_B2)].size() > 0)
                  void'(arc_lists[int'(arc_pkg::LIST_B2)].pop_front());
               make_room(1'b0, r);
            end
         end
         arc_lists[int'(arc_pkg::LIST_T1)].push_back(pg);
      end
      return r;
   endfunction

   task automatic write_size(input logic [arc_pkg::SIZE_W-1:0] sz);
      if (start) begin
         start <= 1'b0;
         @(posedge clock);
      end
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid      <= 1'b1;
      csr_cache_size <= sz;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      size_reg = sz;
      flush_lists();
   endtask

   // Presents one request and returns once the transaction has been accepted.
   task automatic send_page(input logic [arc_pkg::PAGE_W-1:0] pg, input bit fixed,
                            input arc_result_type fixed_res);
      arc_result_type r;
      if (allow_idle && start && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start    <= 1'b1;
      req_page <= pg;
      do @(posedge clock); while (busy);
      r = arc_lookup(pg);
      pending_results.push_back(fixed ? fixed_res : r);
   endtask

   task automatic add_row(input bit is_cfg, input logic [arc_pkg::PAGE_W-1:0] v,
                          input bit fixed, input arc_result_type res);
      stim_row_type row;
      row.is_cfg = is_cfg;
      row.fixed  = fixed;
      row.value  = v;
      row.res    = res;
      dir_rows.push_back(row);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("%0t timeout", $time);
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      arc_result_type want;
      arc_result_type got;
      if (!reset && rsp_valid) begin
         got = {rsp_hit, rsp_ghost_hit, rsp_evict_valid, rsp_evicted_page};
         if (pending_results.size() == 0) begin
            $display("%0t unexpected result: %h", $time, got);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (got.hit !== want.hit) begin
               $display("%0t hit: expected %b, got %b", $time, want.hit, got.hit);
               errors++;
            end
            if (got.ghost !== want.ghost) begin
               $display("%0t ghost_hit: expected %0d, got %0d", $time, want.ghost, got.ghost);
               errors++;
            end
            if (got.evict_valid !== want.evict_valid) begin
               $display("%0t evict_valid: expected %b, got %b", $time,
                        want.evict_valid, got.evict_valid);
               errors++;
            end
            if (got.evicted_page !== want.evicted_page) begin
               $display("%0t evicted_page: expected %h, got %h", $time,
                        want.evicted_page, got.evicted_page);
               errors++;
            end
         end
      end
   end

   initial begin
      logic [arc_pkg::PAGE_W-1:0] base;
      logic [arc_pkg::PAGE_W-1:0] pg;
      logic [arc_pkg::SIZE_W-1:0] sz;
      int pool;
      arc_result_type none;
      none = '0;
      flush_lists();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows; fixed expectations are those obvious from an empty cache.
      add_row(1'b0, 32'h0000_0000, 1'b1, none);
      add_row(1'b0, 32'hFFFF_FFFF, 1'b1, none);
      add_row(1'b0, 32'h0000_0000, 1'b1, '{hit: 1'b1, default: '0});
      add_row(1'b0, 32'h8000_0000, 1'b0, none);
      add_row(1'b1, 32'd1, 1'b0, none);
      add_row(1'b0, 32'd5, 1'b1, none);
      // A cache of one page: the next miss evicts the first page with no ghost.
      add_row(1'b0, 32'd6, 1'b1, '{evict_valid: 1'b1, evicted_page: 32'd5, default: '0});
      add_row(1'b1, 32'd0, 1'b0, none);      // zero size is taken as one
      add_row(1'b0, 32'd7, 1'b1, none);
      add_row(1'b0, 32'd8, 1'b1, '{evict_valid: 1'b1, evicted_page: 32'd7, default: '0});
      add_row(1'b1, 32'd127, 1'b0, none);    // oversized, clamped to capacity
      add_row(1'b0, 32'h5555_AAAA, 1'b0, none);
      add_row(1'b0, 32'hAAAA_5555, 1'b0, none);
      add_row(1'b1, 32'd2, 1'b0, none);
      add_row(1'b0, 32'd1, 1'b0, none);
      add_row(1'b0, 32'd2, 1'b0, none);
      add_row(1'b0, 32'd1, 1'b0, none);
      add_row(1'b0, 32'd3, 1'b0, none);
      add_row(1'b0, 32'd2, 1'b0, none);      // recent ghost hit
      add_row(1'b0, 32'd4, 1'b0, none);
      add_row(1'b0, 32'd5, 1'b0, none);
      add_row(1'b0, 32'd1, 1'b0, none);
      add_row(1'b0, 32'd3, 1'b0, none);
      add_row(1'b0, 32'd6, 1'b0, none);
      add_row(1'b0, 32'd2, 1'b0, none);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg) write_size(dir_rows[i].value[arc_pkg::SIZE_W-1:0]);
         else send_page(dir_rows[i].value, dir_rows[i].fixed, dir_rows[i].res);
      end

      for (int ph = 0; ph < N_PHASES; ph++) begin
         case (ph)
            0: sz = 7'd64;
            1: sz = 7'd1;
            2: sz = 7'd127;
            3: sz = 7'd0;
            4: sz = 7'd4;
            5: sz = 7'd8;
            default: sz = 7'($urandom_range(1, 64));
         endcase
         write_size(sz);
         allow_idle = (ph < N_PHASES - 2);
         base = $urandom();
         pool = (sz == 0) ? 3 : ((sz > CAP) ? 2 * CAP + 8 : 3 * sz + 2);
         for (int n = 0; n < PHASE_LEN; n++) begin
            if ($urandom_range(0, 19) == 0) pg = $urandom();
            else pg = base + $urandom_range(0, pool);
            send_page(pg, 1'b0, none);
         end
      end

      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
